/* hw/rtl/rtu_frame_checker_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef RTU_FRAME_CHECKER_CORE_ASSERT_SVH
`define RTU_FRAME_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* hw/rtl/rfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, codes and the CRC-16/MODBUS byte update for the RTU frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int RFC_MAX_FRAME_BYTES = 256;
    localparam int RFC_CFG_IDX_W       = 2;
    localparam int RFC_Q_DEPTH         = 4;
    localparam int RFC_Q_PTR_W         = 2;
    localparam int RFC_Q_CNT_W         = 3;
    localparam int RFC_MIN_FRAME       = 4;

    localparam logic [RFC_CFG_IDX_W-1:0] REG_MIN_ADDRESS = 2'd0;
    localparam logic [RFC_CFG_IDX_W-1:0] REG_MAX_ADDRESS = 2'd1;

    localparam logic [7:0] MIN_ADDRESS_RST = 8'd1;
    localparam logic [7:0] MAX_ADDRESS_RST = 8'd247;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_ADDRESS  = 3'd2;
    localparam logic [2:0] ST_FUNCTION = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       has_status;
        logic [2:0] status;
        logic [7:0] addr;
        logic [7:0] func;
        logic [7:0] plen;
    } t_job;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic [7:0] slave_address;
        logic [7:0] function_code;
        logic [7:0] payload_length;
        logic       last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/rfc_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_intf
// Valid/ready channels of the RTU frame checker: bytes in, results out, config.
// ----------------------------------------------------------------------------
interface rfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;
    modport source(output valid, rx_byte, end_of_frame, input ready);
    modport sink(input valid, rx_byte, end_of_frame, output ready);
endinterface

interface rfc_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [7:0] slave_address;
    logic [7:0] function_code;
    logic [7:0] payload_length;
    logic       last;
    modport source(output valid, kind, payload_byte, status, slave_address, function_code,
                   payload_length, last, input ready);
    modport sink(input valid, kind, payload_byte, status, slave_address, function_code,
                 payload_length, last, output ready);
endinterface

interface rfc_cfg_if import rfc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [RFC_CFG_IDX_W-1:0] index;
    logic [7:0]               data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/rtu_frame_checker_core.sv */
`timescale 1ns / 1ps
// Modbus RTU frame checker. One received byte is taken per clock cycle while
// the job queue is not full; the CRC-16/MODBUS byte update and all frame
// checks settle in the single front stage, so input throughput is one byte
// per cycle unless the queue is full. Results leave through an output
// register at one beat per cycle while the receiver is ready: every byte
// from the fifth on yields one data beat, and the end-of-frame byte adds
// the status beat. A four-entry job queue between the front and the back
// absorbs status beats and output stalls, and feeds the output register.
// ----------------------------------------------------------------------------
// rtu_frame_checker_core
// Top level: byte front end, job queue and result back end.
// ----------------------------------------------------------------------------
module rtu_frame_checker_core import rfc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = RFC_MAX_FRAME_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfc_in_if.sink    i_rx,
    rfc_cfg_if.sink   i_cfg,
    rfc_out_if.source o_res
);

    t_q_flags w_q_flags;
    t_job     w_job;
    t_job     w_head;
    logic     w_push;
    logic     w_pop;

    rfc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_cfg    (i_cfg),
        .i_q_flags(w_q_flags),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    rfc_job_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job),
        .i_pop  (w_pop),
        .o_head (w_head),
        .o_flags(w_q_flags)
    );

    rfc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_flags(w_q_flags),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

endmodule

/* hw/rtl/rfc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_front
// Takes frame bytes, runs the CRC, tracks the frame and queues result jobs.
// ----------------------------------------------------------------------------
module rfc_front import rfc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = RFC_MAX_FRAME_BYTES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rfc_in_if.sink   i_rx,
    rfc_cfg_if.sink  i_cfg,
    input  t_q_flags i_q_flags,
    output logic     o_push,
    output t_job     o_job
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int EXT_W = CNT_W + 8;

    logic [7:0]       r_min_addr;
    logic [7:0]       r_max_addr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [15:0]      r_crc;
    logic [15:0]      r_crc_prev;
    logic [7:0]       r_bh0;
    logic [7:0]       r_bh1;
    logic [7:0]       r_addr;
    logic [7:0]       n_addr;
    logic [7:0]       r_func;
    logic [7:0]       n_func;
    logic             w_accept;
    logic             w_has_data;
    logic [EXT_W-1:0] w_len_ext;
    logic [2:0]       w_status;

    assign i_rx.ready  = !i_q_flags.full;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_rx.valid && i_rx.ready;
    assign w_has_data  = r_count >= CNT_W'(RFC_MIN_FRAME);

    always_comb begin
        n_addr    = (r_count == '0) ? i_rx.rx_byte : r_addr;
        n_func    = (r_count == CNT_W'(1)) ? i_rx.rx_byte : r_func;
        n_count   = (r_count <= CNT_W'(MAX_FRAME_BYTES)) ? r_count + CNT_W'(1) : r_count;
        w_len_ext = EXT_W'(n_count) - EXT_W'(RFC_MIN_FRAME);
        if (n_count < CNT_W'(RFC_MIN_FRAME) || n_count > CNT_W'(MAX_FRAME_BYTES)) begin
            w_status = ST_LENGTH;
        end else if (n_addr < r_min_addr || n_addr > r_max_addr) begin
            w_status = ST_ADDRESS;
        end else if (n_func == 8'h00) begin
            w_status = ST_FUNCTION;
        end else if (r_crc_prev != {i_rx.rx_byte, r_bh0}) begin
            w_status = ST_CRC;
        end else begin
            w_status = ST_OK;
        end
    end

    assign o_push          = w_accept && (w_has_data || i_rx.end_of_frame);
    assign o_job.has_data   = w_has_data;
    assign o_job.data       = r_bh1;
    assign o_job.has_status = i_rx.end_of_frame;
    assign o_job.status     = w_status;
    assign o_job.addr       = n_addr;
    assign o_job.func       = n_func;
    assign o_job.plen       = (w_status == ST_OK) ? w_len_ext[7:0] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_addr <= MIN_ADDRESS_RST;
            r_max_addr <= MAX_ADDRESS_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MIN_ADDRESS: r_min_addr <= i_cfg.data;
                REG_MAX_ADDRESS: r_max_addr <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_crc_prev <= CRC_INIT;
            r_bh0      <= 8'h00;
            r_bh1      <= 8'h00;
            r_addr     <= 8'h00;
            r_func     <= 8'h00;
        end else if (w_accept) begin
            if (i_rx.end_of_frame) begin
                r_count    <= '0;
                r_crc      <= CRC_INIT;
                r_crc_prev <= CRC_INIT;
                r_bh0      <= 8'h00;
                r_bh1      <= 8'h00;
                r_addr     <= 8'h00;
                r_func     <= 8'h00;
            end else begin
                r_count    <= n_count;
                r_crc      <= crc16_byte(r_crc, i_rx.rx_byte);
                r_crc_prev <= r_crc;
                r_bh0      <= i_rx.rx_byte;
                r_bh1      <= r_bh0;
                r_addr     <= n_addr;
                r_func     <= n_func;
            end
        end
    end

endmodule

/* hw/rtl/rfc_job_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_job_fifo
// Short job queue between the byte front end and the result back end.
// ----------------------------------------------------------------------------
module rfc_job_fifo import rfc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_job     i_job,
    input  logic     i_pop,
    output t_job     o_head,
    output t_q_flags o_flags
);

    t_job                   r_mem [RFC_Q_DEPTH];
    logic [RFC_Q_PTR_W-1:0] r_wr;
    logic [RFC_Q_PTR_W-1:0] r_rd;
    logic [RFC_Q_CNT_W-1:0] r_cnt;
    logic                   w_push;
    logic                   w_pop;

    assign o_flags.full  = r_cnt == RFC_Q_CNT_W'(RFC_Q_DEPTH);
    assign o_flags.empty = r_cnt == '0;
    assign w_push        = i_push && !o_flags.full;
    assign w_pop         = i_pop && !o_flags.empty;
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + RFC_Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + RFC_Q_PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + RFC_Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - RFC_Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/rfc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_back
// Turns queued jobs into data and status beats through an output register.
// ----------------------------------------------------------------------------
module rfc_back import rfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_q_flags  i_q_flags,
    output logic      o_pop,
    rfc_out_if.source o_res
);

    logic    r_valid;
    logic    r_data_done;
    logic    n_data_done;
    t_result r_res;
    t_result n_res;
    logic    w_load;
    logic    w_emit_data;

    assign w_load      = (!r_valid || o_res.ready) && !i_q_flags.empty;
    assign w_emit_data = i_head.has_data && !r_data_done;

    always_comb begin
        n_res       = '0;
        n_data_done = r_data_done;
        o_pop       = 1'b0;
        if (w_emit_data) begin
            n_res.kind         = KIND_DATA;
            n_res.payload_byte = i_head.data;
        end else begin
            n_res.kind           = KIND_STATUS;
            n_res.status         = i_head.status;
            n_res.slave_address  = i_head.addr;
            n_res.function_code  = i_head.func;
            n_res.payload_length = i_head.plen;
            n_res.last           = 1'b1;
        end
        if (w_load) begin
            if (w_emit_data && i_head.has_status) begin
                n_data_done = 1'b1;
            end else begin
                n_data_done = 1'b0;
                o_pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_data_done <= 1'b0;
        end else begin
            r_data_done <= n_data_done;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.kind           = r_res.kind;
    assign o_res.payload_byte   = r_res.payload_byte;
    assign o_res.status         = r_res.status;
    assign o_res.slave_address  = r_res.slave_address;
    assign o_res.function_code  = r_res.function_code;
    assign o_res.payload_length = r_res.payload_length;
    assign o_res.last           = r_res.last;

endmodule

/* hw/rtl/rfc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks on the result channel of the RTU frame checker.
// ----------------------------------------------------------------------------
`include "rtu_frame_checker_core_assert.svh"

module rfc_checker import rfc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_kind,
    input logic [7:0] i_payload_byte,
    input logic [2:0] i_status,
    input logic [7:0] i_slave_address,
    input logic [7:0] i_function_code,
    input logic [7:0] i_payload_length,
    input logic       i_last
);

    logic w_data_clean;
    logic w_err_clean;

    assign w_data_clean = i_status == ST_OK && i_slave_address == 8'd0 &&
                          i_function_code == 8'd0 && i_payload_length == 8'd0;
    assign w_err_clean  = i_payload_length == 8'd0 && i_payload_byte == 8'd0 &&
                          i_status <= ST_CRC;

    `RFC_ASSERT_IMPLY(a_last_on_status, i_clk, i_rst_n, i_valid, i_last == i_kind)
    `RFC_ASSERT_IMPLY(a_data_clean, i_clk, i_rst_n, i_valid && !i_kind, w_data_clean)
    `RFC_ASSERT_IMPLY(a_error_no_len, i_clk, i_rst_n, i_valid && i_kind && i_status != ST_OK, w_err_clean)
    `RFC_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_kind) && $stable(i_payload_byte) && $stable(i_status))

endmodule

bind rtu_frame_checker_core rfc_checker u_rfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_kind          (o_res.kind),
    .i_payload_byte  (o_res.payload_byte),
    .i_status        (o_res.status),
    .i_slave_address (o_res.slave_address),
    .i_function_code (o_res.function_code),
    .i_payload_length(o_res.payload_length),
    .i_last          (o_res.last)
);

/* bench/tb_rtu_frame_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtu_frame_checker_core
// Self-checking bench: streams Modbus RTU frames (good, corrupted, short,
// over-long and noise) under several address windows, predicts every data
// and status beat and compares the result channel against it in order.
// ----------------------------------------------------------------------------
module tb_rtu_frame_checker_core;
    import rfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 5;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_frame_beat;

    typedef enum {RDY_FREE, RDY_PERIODIC, RDY_SPARSE, RDY_COIN} t_ready_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfc_in_if  rx_if ();
    rfc_out_if res_if ();
    rfc_cfg_if cfg_if ();

    rtu_frame_checker_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // stimulus backlog and expected beats
    t_frame_beat rx_backlog[$];
    t_result     due_results[$];

    // predictor state
    logic [7:0]  addr_lo;
    logic [7:0]  addr_hi;
    int          fr_count;
    logic [15:0] fr_crc;
    logic [15:0] fr_crc_hist[2];
    logic [7:0]  fr_byte_hist[2];
    logic [7:0]  fr_addr;
    logic [7:0]  fr_func;

    int n_fail;
    int n_in;
    int n_out;
    int n_queued;
    int n_frames;
    int st_seen[5];

    function automatic logic [15:0] crc_modbus_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = {acc[15:8], acc[7:0] ^ b};
        repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ 16'hA001) : {1'b0, c[15:1]};
        return c;
    endfunction

    function automatic void frame_clear();
        fr_count        = 0;
        fr_crc          = 16'hFFFF;
        fr_crc_hist[0]  = 16'hFFFF;
        fr_crc_hist[1]  = 16'hFFFF;
        fr_byte_hist[0] = 8'h00;
        fr_byte_hist[1] = 8'h00;
        fr_addr         = 8'h00;
        fr_func         = 8'h00;
    endfunction

    function automatic void absorb_rx_byte(input logic [7:0] b, input logic eof);
        t_result     r;
        logic [15:0] rx_crc;
        logic [2:0]  st;
        if (fr_count == 0) begin
            fr_addr = b;
        end else if (fr_count == 1) begin
            fr_func = b;
        end
        if (fr_count >= 4) begin
            r              = '0;
            r.kind         = KIND_DATA;
            r.payload_byte = fr_byte_hist[1];
            due_results.push_back(r);
        end
        fr_crc_hist[1]  = fr_crc_hist[0];
        fr_crc_hist[0]  = fr_crc;
        fr_crc          = crc_modbus_step(fr_crc, b);
        fr_byte_hist[1] = fr_byte_hist[0];
        fr_byte_hist[0] = b;
        if (fr_count <= RFC_MAX_FRAME_BYTES) fr_count++;
        if (eof) begin
            rx_crc = {fr_byte_hist[0], fr_byte_hist[1]};
            if (fr_count < RFC_MIN_FRAME || fr_count > RFC_MAX_FRAME_BYTES) begin
                st = ST_LENGTH;
            end else if (fr_addr < addr_lo || fr_addr > addr_hi) begin
                st = ST_ADDRESS;
            end else if (fr_func == 8'h00) begin
                st = ST_FUNCTION;
            end else if (fr_crc_hist[1] != rx_crc) begin
                st = ST_CRC;
            end else begin
                st = ST_OK;
            end
            r                = '0;
            r.kind           = KIND_STATUS;
            r.status         = st;
            r.slave_address  = fr_addr;
            r.function_code  = fr_func;
            r.payload_length = (st == ST_OK) ? 8'(fr_count - RFC_MIN_FRAME) : 8'h00;
            r.last           = 1'b1;
            due_results.push_back(r);
            n_frames++;
            st_seen[int'(st)]++;
            frame_clear();
        end
    endfunction

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            n_fail++;
        end
    endfunction

    // ------------------------------------------------------------------ driver
    int          burst_left;
    int          gap_left;
    t_frame_beat nxt_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                absorb_rx_byte(rx_if.rx_byte, rx_if.end_of_frame);
                n_in++;
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx_if.valid <= 1'b0;
                end else if (rx_backlog.size() > 0) begin
                    nxt_beat = rx_backlog.pop_front();
                    rx_if.valid        <= 1'b1;
                    rx_if.rx_byte      <= nxt_beat.data;
                    rx_if.end_of_frame <= nxt_beat.eof;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // ----------------------------------------------------------------- monitor
    t_ready_mode rdy_mode;
    int          rdy_left;
    int          rdy_cyc;
    int          hold_left;
    bit          hold_done;
    bit          rdy_go;
    t_result     want_res;
    t_result     got_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rdy_left  = 0;
            rdy_cyc   = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_out++;
                got_res = '{res_if.kind, res_if.payload_byte, res_if.status,
                            res_if.slave_address, res_if.function_code,
                            res_if.payload_length, res_if.last};
                if (due_results.size() == 0) begin
                    $display("%0t ns: unexpected beat, expected none, actual %h", $time, got_res);
                    n_fail++;
                end else begin
                    want_res = due_results.pop_front();
                    check_field("kind", want_res.kind, got_res.kind);
                    check_field("payload_byte", want_res.payload_byte, got_res.payload_byte);
                    check_field("status", want_res.status, got_res.status);
                    check_field("slave_address", want_res.slave_address, got_res.slave_address);
                    check_field("function_code", want_res.function_code, got_res.function_code);
                    check_field("payload_length", want_res.payload_length,
                                got_res.payload_length);
                    check_field("last", want_res.last, got_res.last);
                end
            end
            rdy_cyc++;
            if (rdy_left == 0) begin
                rdy_mode = t_ready_mode'($urandom_range(0, 3));
                rdy_left = $urandom_range(20, 120);
            end else begin
                rdy_left--;
            end
            // one long back-pressure stretch to fill the job queue
            if (!hold_done && n_in >= 100) begin
                hold_done = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy_go = 1'b0;
            end else begin
                case (rdy_mode)
                    RDY_FREE:     rdy_go = 1'b1;
                    RDY_PERIODIC: rdy_go = (rdy_cyc % 5) != 0;
                    RDY_SPARSE:   rdy_go = $urandom_range(0, 3) != 0;
                    default:      rdy_go = $urandom_range(0, 1);
                endcase
            end
            res_if.ready <= rdy_go;
        end
    end

    // ---------------------------------------------------------------- watchdog
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
                     (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no beat for %0d cycles, %0d beats still due",
                         $time, idle_cycles, due_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------- stimulus
    task automatic push_beat(input logic [7:0] b, input logic eof);
        rx_backlog.push_back('{b, eof});
        n_queued++;
    endtask

    task automatic add_frame(input logic [7:0] addr, input logic [7:0] func, input int plen,
                             input bit bad_crc);
        logic [15:0] c;
        logic [7:0]  b;
        c = 16'hFFFF;
        push_beat(addr, 1'b0);
        c = crc_modbus_step(c, addr);
        push_beat(func, 1'b0);
        c = crc_modbus_step(c, func);
        repeat (plen) begin
            b = 8'($urandom);
            push_beat(b, 1'b0);
            c = crc_modbus_step(c, b);
        end
        if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
        push_beat(c[7:0], 1'b0);
        push_beat(c[15:8], 1'b1);
    endtask

    task automatic add_raw(input int len);
        repeat (len - 1) push_beat(8'($urandom), 1'b0);
        push_beat(8'($urandom), 1'b1);
    endtask

    function automatic logic [7:0] pick_addr();
        if (addr_lo <= addr_hi) return 8'($urandom_range(addr_lo, addr_hi));
        return 8'($urandom);
    endfunction

    task automatic rand_traffic(input int nbytes, input int big_plen);
        int          start;
        int          plen;
        logic [7:0]  func;
        start = n_queued;
        if (big_plen > 0) add_frame(pick_addr(), 8'($urandom_range(1, 255)), big_plen, 1'b0);
        while (n_queued - start < nbytes) begin
            plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 4);
            func = 8'($urandom_range(1, 255));
            case ($urandom_range(0, 19))
                14:      add_frame(pick_addr(), func, plen, 1'b1);
                15:      add_frame(pick_addr(), 8'h00, plen, 1'b0);
                16:      add_frame(8'($urandom), func, plen, 1'b0);
                17:      add_raw($urandom_range(1, 3));
                18:      add_raw($urandom_range(4, 12));
                19:      add_frame($urandom_range(0, 1) ? addr_lo : addr_hi, func, plen, 1'b0);
                default: add_frame(pick_addr(), func, plen, 1'b0);
            endcase
        end
    endtask

    task automatic write_reg(input logic [RFC_CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == REG_MIN_ADDRESS) begin
            addr_lo = val;
        end else begin
            addr_hi = val;
        end
        cfg_if.valid <= 1'b0;
    endtask

    // sender holds back until every due beat is out, then lets the block settle
    task automatic drain_results();
        while (rx_backlog.size() != 0 || rx_if.valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    logic [7:0] lo_set[PHASES];
    logic [7:0] hi_set[PHASES];
    int         big_set[PHASES];

    initial begin
        i_rst_n             = 1'b0;
        rx_if.valid         = 1'b0;
        rx_if.rx_byte       = 8'h00;
        rx_if.end_of_frame  = 1'b0;
        res_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = REG_MIN_ADDRESS;
        cfg_if.data         = 8'h00;
        addr_lo             = MIN_ADDRESS_RST;
        addr_hi             = MAX_ADDRESS_RST;
        n_fail   = 0;
        n_in     = 0;
        n_out    = 0;
        n_queued = 0;
        n_frames = 0;
        foreach (st_seen[i]) st_seen[i] = 0;
        frame_clear();

        lo_set = '{8'd0, 8'd200, 8'd0, 8'($urandom), MIN_ADDRESS_RST};
        hi_set = '{8'd255, 8'd100, 8'd0, 8'($urandom), MAX_ADDRESS_RST};
        lo_set[2] = 8'($urandom);
        hi_set[2] = lo_set[2];
        // full-size frame, then a few bytes past the limit so the count saturates
        big_set = '{RFC_MAX_FRAME_BYTES - RFC_MIN_FRAME, 0, 0, 0, RFC_MAX_FRAME_BYTES - 1};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under the reset address window
        add_frame(MIN_ADDRESS_RST, 8'h03, 0, 1'b0);
        add_frame(MAX_ADDRESS_RST, 8'hFF, 1, 1'b0);
        add_frame(8'h00, 8'h01, 0, 1'b0);
        add_frame(8'h11, 8'h00, 0, 1'b0);
        add_frame(8'h11, 8'h04, 0, 1'b1);
        add_raw(1);
        add_raw(3);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_MIN_ADDRESS, lo_set[ph]);
            write_reg(REG_MAX_ADDRESS, hi_set[ph]);
            rand_traffic(50, big_set[ph]);
            drain_results();
        end

        $display("Run covered %0d frame bytes, %0d result beats, %0d address windows",
                 n_in, n_out, PHASES + 1);
        $display("Frames %0d: ok %0d, length %0d, address %0d, function %0d, crc %0d",
                 n_frames, st_seen[int'(ST_OK)], st_seen[int'(ST_LENGTH)],
                 st_seen[int'(ST_ADDRESS)], st_seen[int'(ST_FUNCTION)], st_seen[int'(ST_CRC)]);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
